/* hdl/jqcd_pkg.sv */
package jqcd_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_TAKE        = 3'd1,
    OP_CANCEL      = 3'd2,
    OP_STOP        = 3'd3,
    OP_IDLE_ENTER  = 3'd4,
    OP_IDLE_LEAVE  = 3'd5,
    OP_WORKER_EXIT = 3'd6
  } op_e;

  // Result codes carried in the output tuser field.
  typedef enum logic [2:0] {
    ACT_OK      = 3'd0,
    ACT_WOKE    = 3'd1,
    ACT_SPAWN   = 3'd2,
    ACT_SYNC    = 3'd3,
    ACT_STOPPED = 3'd4,
    ACT_FULL    = 3'd5
  } act_e;

  localparam int WORKER_W = 6;
  localparam logic [WORKER_W-1:0] WORKER_MAX = '1;
  localparam logic [WORKER_W-1:0] WORKER_LIMIT_RESET = 6'd4;

  // One job entry; the identifier sits in the lowest bits.
  typedef struct packed {
    logic [15:0]        context_tag;
    logic [15:0]        handler_tag;
    logic signed [31:0] job_id;
  } job_t;

  // Fixed-width part of a result transaction.
  typedef struct packed {
    act_e action;
    logic job_valid;
    job_t job;
  } resp_t;

endpackage

/* hdl/jqcd_store.sv */
module jqcd_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  jqcd_pkg::job_t   wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output jqcd_pkg::job_t   rdata
);

  jqcd_pkg::job_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Single read port with registered output.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/jqcd_ctrl.sv */
module jqcd_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request side.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_op,
  input  jqcd_pkg::job_t                   in_job,
  input  logic [jqcd_pkg::WORKER_W-1:0]    worker_limit,
  // Result side.
  output logic                             res_valid,
  input  logic                             res_ready,
  output jqcd_pkg::resp_t                  res,
  output logic [CW-1:0]                    res_removed,
  output logic [CW-1:0]                    res_queued,
  output logic [jqcd_pkg::WORKER_W-1:0]    res_workers,
  // Job store.
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output jqcd_pkg::job_t                   mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  jqcd_pkg::job_t                   mem_rdata
);

  localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                        state;
  jqcd_pkg::op_e                 op;
  jqcd_pkg::job_t                req;
  logic [AW-1:0]                 head;
  logic [CW-1:0]                 fill;
  logic                          stopped;
  logic [jqcd_pkg::WORKER_W-1:0] workers;
  logic [jqcd_pkg::WORKER_W-1:0] idle_cnt;
  logic [CW-1:0]                 rd_idx;
  logic                          pend;
  logic [CW-1:0]                 kept;
  logic [CW-1:0]                 removed;

  logic [AW-1:0]                 head_next;
  logic [CW-1:0]                 fill_next;
  logic                          stopped_next;
  logic [jqcd_pkg::WORKER_W-1:0] workers_next;
  logic [jqcd_pkg::WORKER_W-1:0] idle_next;
  jqcd_pkg::act_e                act;
  logic                          sync_run;
  logic                          add_wr;
  logic                          take_rd;
  logic                          scan_go;
  logic                          accept;
  logic                          issue;
  logic                          match;

  // Physical slot of a queue position, wrapping at the queue depth.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE) || ((state == S_EMIT) && res_ready);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_EMIT);
  assign issue     = (rd_idx != fill);
  assign match     = (mem_rdata == req);

  // Decision for the operation held in the request register.
  always_comb begin
    head_next    = head;
    fill_next    = fill;
    stopped_next = stopped;
    workers_next = workers;
    idle_next    = idle_cnt;
    act          = jqcd_pkg::ACT_OK;
    sync_run     = 1'b0;
    add_wr       = 1'b0;
    take_rd      = 1'b0;
    scan_go      = 1'b0;
    unique case (op)
      jqcd_pkg::OP_ADD: begin
        if (stopped) begin
          act = jqcd_pkg::ACT_STOPPED;
        end else if (worker_limit == '0) begin
          act      = jqcd_pkg::ACT_SYNC;
          sync_run = 1'b1;
        end else if (fill == FULL_CNT) begin
          act = jqcd_pkg::ACT_FULL;
        end else begin
          add_wr    = 1'b1;
          fill_next = fill + 1'b1;
          if (idle_cnt != '0) begin
            act = jqcd_pkg::ACT_WOKE;
          end else if (workers >= worker_limit) begin
            act = jqcd_pkg::ACT_OK;
          end else begin
            workers_next = workers + 1'b1;
            act          = jqcd_pkg::ACT_SPAWN;
          end
        end
      end
      jqcd_pkg::OP_TAKE: begin
        if (!stopped && (fill != '0)) begin
          take_rd   = 1'b1;
          head_next = slot_of(head, CW'(1));
          fill_next = fill - 1'b1;
        end
      end
      jqcd_pkg::OP_CANCEL: begin
        scan_go = 1'b1;
      end
      jqcd_pkg::OP_STOP: begin
        stopped_next = 1'b1;
      end
      jqcd_pkg::OP_IDLE_ENTER: begin
        if (idle_cnt != jqcd_pkg::WORKER_MAX) begin
          idle_next = idle_cnt + 1'b1;
        end
      end
      jqcd_pkg::OP_IDLE_LEAVE: begin
        if (idle_cnt != '0) begin
          idle_next = idle_cnt - 1'b1;
        end
      end
      jqcd_pkg::OP_WORKER_EXIT: begin
        if (workers != '0) begin
          workers_next = workers - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Store accesses. During a cancel scan, reads run ahead of the compacting
  // writes, so a write never lands on an entry that is still to be read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_of(head, fill);
    mem_wdata = req;
    mem_re    = 1'b0;
    mem_raddr = head;
    if (state == S_EXEC) begin
      mem_we = add_wr;
      mem_re = take_rd;
    end else if (state == S_SCAN) begin
      mem_re    = issue;
      mem_raddr = slot_of(head, rd_idx);
      mem_waddr = slot_of(head, kept);
      mem_wdata = mem_rdata;
      mem_we    = pend && !match && (removed != '0);
    end
  end

  // Sequencer, queue state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      fill     <= '0;
      stopped  <= 1'b0;
      workers  <= '0;
      idle_cnt <= '0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= jqcd_pkg::op_e'(in_op);
            req   <= in_job;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          head          <= head_next;
          fill          <= fill_next;
          stopped       <= stopped_next;
          workers       <= workers_next;
          idle_cnt      <= idle_next;
          res.action    <= act;
          res.job_valid <= sync_run;
          res.job       <= sync_run ? req : '0;
          res_removed   <= '0;
          res_queued    <= stopped_next ? '0 : fill_next;
          res_workers   <= workers_next;
          if (take_rd) begin
            state <= S_READ;
          end else if (scan_go) begin
            rd_idx  <= '0;
            kept    <= '0;
            removed <= '0;
            pend    <= 1'b0;
            state   <= S_SCAN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_READ: begin
          res.job_valid <= 1'b1;
          res.job       <= mem_rdata;
          state         <= S_EMIT;
        end
        S_SCAN: begin
          rd_idx <= rd_idx + CW'(issue);
          pend   <= issue;
          if (pend) begin
            if (match) begin
              removed <= removed + 1'b1;
            end else begin
              kept <= kept + 1'b1;
            end
          end
          // Scan finished: every entry read and compared.
          if (!issue && !pend) begin
            fill          <= kept;
            res.action    <= jqcd_pkg::ACT_OK;
            res.job_valid <= 1'b0;
            res.job       <= '0;
            res_removed   <= removed;
            res_queued    <= stopped ? '0 : kept;
            res_workers   <= workers;
            state         <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            if (accept) begin
              op    <= jqcd_pkg::op_e'(in_op);
              req   <= in_job;
              state <= S_EXEC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

/* hdl/job_queue_with_cancel_and_dispatch_unit.sv */
// Channel   Direction  tdata / tuser contents
// s_*       in         tdata: job_id, handler_tag, context_tag; tuser: op
// m_*       out        tdata: job_valid, job, removed, queued, workers;
//                      tuser: action
// cfg_*     in         worker_limit write, taken whenever cfg_we is high
//
// Add, stop, idle, worker-exit and unused-code transactions go from the execute state
// straight to the result, as does a take on an empty or stopped queue; a take that
// returns a job also passes a read state, as the job store read is registered.
// Cancel scans the queue, dropping entries equal to the request and compacting the
// rest; the scan reads one store entry per cycle through the single read port.
// Reset is synchronous and clears the queue pointers, counters and sequencer state;
// store contents are left undefined and need no clearing pass.
// One finished result waits in the output register while the next is built.
module job_queue_with_cancel_and_dispatch_unit #(
  parameter int QUEUE_DEPTH = 16,
  localparam int AW       = $clog2(QUEUE_DEPTH),
  localparam int CW       = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_BITS = 65 + 2 * CW + jqcd_pkg::WORKER_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jqcd_pkg::WORKER_W-1:0]       cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // job_id [31:0], handler_tag [47:32], context_tag [63:48]
  input  logic [63:0]                         s_tdata,
  // op [2:0]
  input  logic [2:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // job_valid, out_job_id, out_handler_tag, out_context_tag, removed_count,
  // queued_count, worker_count, then zero fill
  output logic [OUT_W-1:0]                    m_tdata,
  // action [2:0]
  output logic [2:0]                          m_tuser
);

  logic [jqcd_pkg::WORKER_W-1:0] worker_limit;
  logic                          res_valid;
  logic                          res_ready;
  jqcd_pkg::resp_t               res;
  logic [CW-1:0]                 res_removed;
  logic [CW-1:0]                 res_queued;
  logic [jqcd_pkg::WORKER_W-1:0] res_workers;
  jqcd_pkg::resp_t               out_res;
  logic [CW-1:0]                 out_removed;
  logic [CW-1:0]                 out_queued;
  logic [jqcd_pkg::WORKER_W-1:0] out_workers;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  jqcd_pkg::job_t                mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  jqcd_pkg::job_t                mem_rdata;

  // Worker limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      worker_limit <= jqcd_pkg::WORKER_LIMIT_RESET;
    end else if (cfg_we) begin
      worker_limit <= cfg_wdata;
    end
  end

  jqcd_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op        (s_tuser),
    .in_job       (jqcd_pkg::job_t'(s_tdata)),
    .worker_limit (worker_limit),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .res_removed  (res_removed),
    .res_queued   (res_queued),
    .res_workers  (res_workers),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  jqcd_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid    <= 1'b1;
      out_res     <= res;
      out_removed <= res_removed;
      out_queued  <= res_queued;
      out_workers <= res_workers;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, out_workers, out_queued, out_removed,
                    out_res.job.context_tag, out_res.job.handler_tag,
                    out_res.job.job_id, out_res.job_valid};

`ifndef SYNTH
  // A finished result is held unchanged until the output register takes it.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before hand-off");

  // A result handed to the output register is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("result lost at the output register");

  // Only a take or a synchronous run carries a job.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.job_valid |->
      (out_res.action == jqcd_pkg::ACT_OK || out_res.action == jqcd_pkg::ACT_SYNC))
    else $error("job returned with an unexpected action");

  // The queue never reports more jobs than it can hold.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_queued <= CW'(QUEUE_DEPTH) && out_removed <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
